/* rtl/core/sbf_pkg.sv */
// Shared types and constants for the sinusoid boundary fit evaluator.
// No dependencies.
package sbf_pkg;

  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [31:0] TURN_K_HI   = 32'h28BE_60DB;
  localparam logic [31:0] TURN_K_LO   = 32'h9391_054A;
  localparam logic [31:0] HALF_PI_Q30 = 32'h6487_ED51;

  localparam int SIN_STEPS = 7;
  localparam int COS_STEPS = 8;
  localparam int CELL_LAT  = 3;

  localparam int SIN_DEN [SIN_STEPS] = '{210, 156, 110, 72, 42, 20, 6};
  localparam int COS_DEN [COS_STEPS] = '{240, 182, 132, 90, 56, 30, 12, 2};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EQUAL    = 2'd1,
    ST_OVERSLOPE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_BOUND = 2'd1,
    CFG_SLOPE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    FS_IDLE = 4'b0001,
    FS_MUL  = 4'b0010,
    FS_DIV  = 4'b0100,
    FS_FIN  = 4'b1000
  } fit_state_t;

  // One Horner step's operands, handed cell to cell.
  typedef struct packed {
    logic [31:0]        r2;
    logic signed [31:0] acc;
  } cell_t;

  // Fit terms derived from the configuration registers.
  typedef struct packed {
    logic               busy;
    status_t            status;
    logic signed [63:0] o;
    logic signed [31:0] v;
    logic [61:0]        w;
  } fit_t;

endpackage

/* rtl/core/sbf_horner_cell.sv */
// One Horner step: acc' = 1 - trunc(r2 * acc / (DEN * 2^30)), three stages.
// Depends on sbf_pkg.
module sbf_horner_cell import sbf_pkg::*; #(
  parameter int DEN = 6
) (
  input  logic  clk,
  input  logic  en,
  input  cell_t cin,
  output cell_t cout
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DEN);
  localparam logic [40:0] DEN_W = 41'(DEN);

  logic [62:0] p_r;
  logic [31:0] r2a_r, r2b_r;
  logic [31:0] x_r, q0_r;
  logic [63:0] qm;
  logic [40:0] rem;
  logic [31:0] q;

  // x < 2^32 so the floor reciprocal is off by at most one
  assign qm  = 64'(p_r[61:30]) * 64'(RECIP);
  assign rem = 41'(x_r) - 41'(q0_r) * DEN_W;
  assign q   = q0_r + 32'(rem >= DEN_W);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r       <= 63'(cin.r2) * 63'(cin.acc[30:0]);
      r2a_r     <= cin.r2;
      x_r       <= p_r[61:30];
      q0_r      <= qm[63:32];
      r2b_r     <= r2a_r;
      cout.acc  <= $signed(ONE_Q30 - q);
      cout.r2   <= r2b_r;
    end
  end

endmodule

/* rtl/core/sbf_fit_unit.sv */
// Configuration registers and the fit terms o, w and status.
// Bit-serial divider for v^2/|d|; depends on sbf_pkg.
module sbf_fit_unit import sbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output fit_t        fit
);

  logic signed [31:0] s1_r, s2_r, v_r;
  fit_state_t  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] dm_r, dm_nxt;
  logic        dpos_r, dpos_nxt, dz_r, dz_nxt;
  logic [62:0] sq_r, sq_nxt, quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic signed [63:0] o_r, o_nxt;
  logic [61:0] w_r, w_nxt;
  status_t     st_r, st_nxt;

  logic signed [32:0] d;
  logic [31:0] vm;
  logic [33:0] trial;
  logic [63:0] asum;
  logic [62:0] a;
  logic [62:0] wd;

  assign d     = 33'(s1_r) - 33'(s2_r);
  assign vm    = v_r[31] ? 32'(-33'(v_r)) : 32'(v_r);
  assign trial = {rem_r, sq_r[62]};
  assign asum  = 64'(dm_r) + 64'(quo_r);
  assign a     = asum[63:1];
  assign wd    = (63'(dm_r) > quo_r) ? 63'(dm_r) - quo_r : quo_r - 63'(dm_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dm_nxt    = dm_r;
    dpos_nxt  = dpos_r;
    dz_nxt    = dz_r;
    sq_nxt    = sq_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    o_nxt     = o_r;
    w_nxt     = w_r;
    st_nxt    = st_r;
    case (state_r)
      FS_IDLE: ;
      FS_MUL: begin
        dm_nxt    = d[32] ? 33'(-d) : 33'(d);
        dpos_nxt  = !d[32] && (d != '0);
        dz_nxt    = (d == '0);
        sq_nxt    = 63'(vm) * 63'(vm);
        quo_nxt   = '0;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = FS_DIV;
      end
      FS_DIV: begin
        if (trial >= 34'(dm_r)) begin
          rem_nxt = 33'(trial - 34'(dm_r));
          quo_nxt = {quo_r[61:0], 1'b1};
        end else begin
          rem_nxt = trial[32:0];
          quo_nxt = {quo_r[61:0], 1'b0};
        end
        sq_nxt  = {sq_r[61:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd62) state_nxt = FS_FIN;
      end
      FS_FIN: begin
        w_nxt = wd[62:1];
        o_nxt = dpos_r ? 64'(s2_r) + 64'(a) : 64'(s2_r) - 64'(a);
        if (dz_r) st_nxt = ST_EQUAL;
        else if (63'(vm) > a) st_nxt = ST_OVERSLOPE;
        else st_nxt = ST_OK;
        state_nxt = FS_IDLE;
      end
      default: state_nxt = FS_MUL;
    endcase
    if (cfg_we) state_nxt = FS_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r    <= '0;
      s2_r    <= '0;
      v_r     <= '0;
      state_r <= FS_MUL;
      st_r    <= ST_EQUAL;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START: s1_r <= $signed(cfg_data);
          CFG_BOUND: s2_r <= $signed(cfg_data);
          CFG_SLOPE: v_r  <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    dm_r   <= dm_nxt;
    dpos_r <= dpos_nxt;
    dz_r   <= dz_nxt;
    sq_r   <= sq_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    o_r    <= o_nxt;
    w_r    <= w_nxt;
  end

  assign fit.busy   = (state_r != FS_IDLE);
  assign fit.status = st_r;
  assign fit.o      = o_r;
  assign fit.v      = v_r;
  assign fit.w      = w_r;

endmodule

/* rtl/core/sinusoid_boundary_fit_eval_top.sv */
// Throughput one item per cycle unless the output stalls or a fit run is busy.
// The sine and cosine lanes are rows of Horner cells, three stages per cell.
// Any configuration write reruns the fit on a bit-serial divider, during which
// no item is taken. Reset (rst_n low, synchronous) zeroes config and valid bits,
// sets the status to EQUAL and starts that fit run.
module sinusoid_boundary_fit_eval_top import sbf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_time_now,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_curve_value,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int LANE_LAT = COS_STEPS * CELL_LAT;
  localparam int SIN_LAT  = SIN_STEPS * CELL_LAT;
  localparam int SIN_PAD  = LANE_LAT - SIN_LAT;
  localparam int DEPTH    = 8 + LANE_LAT;

  fit_t fit;
  logic en, acc_in;
  logic [DEPTH-1:0] vld_r;

  sbf_fit_unit u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fit       (fit)
  );

  assign en       = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = en && !fit.busy && !cfg_we;
  assign acc_in   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], acc_in};
  end

  // angle: time scaled to turns, then quadrant and radians
  logic [61:0] hi_r;
  logic [63:0] lo_r;
  logic [62:0] asum;
  logic [31:0] ang_r;
  logic [60:0] rprod;
  logic [30:0] rc_r, rd_r;
  logic [1:0]  qc_r, qd_r;
  logic [61:0] rr;
  logic [31:0] r2_r;

  assign asum  = 63'(hi_r) + 63'(lo_r[63:32]);
  assign rprod = 61'(ang_r[29:0]) * 61'(HALF_PI_Q30);
  assign rr    = 62'(rc_r) * 62'(rc_r);

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r  <= 62'(in_time_now) * 62'(TURN_K_HI);
      lo_r  <= 64'(in_time_now) * 64'(TURN_K_LO);
      ang_r <= asum[FRAC_BITS+31:FRAC_BITS];
      rc_r  <= rprod[60:30];
      qc_r  <= ang_r[31:30];
      r2_r  <= rr[61:30];
      rd_r  <= rc_r;
      qd_r  <= qc_r;
    end
  end

  // Horner lanes
  cell_t lane_in;
  cell_t sin_c [SIN_STEPS+1];
  cell_t cos_c [COS_STEPS+1];

  assign lane_in.r2  = r2_r;
  assign lane_in.acc = $signed(ONE_Q30);
  assign sin_c[0]    = lane_in;
  assign cos_c[0]    = lane_in;

  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    sbf_horner_cell #(.DEN(SIN_DEN[i])) u_cell (
      .clk (clk), .en (en), .cin (sin_c[i]), .cout (sin_c[i+1])
    );
  end

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    sbf_horner_cell #(.DEN(COS_DEN[i])) u_cell (
      .clk (clk), .en (en), .cin (cos_c[i]), .cout (cos_c[i+1])
    );
  end

  // side delay lines for r, quadrant and the shorter sine lane
  logic [30:0] r_dly_r [LANE_LAT];
  logic [1:0]  q_dly_r [LANE_LAT];
  logic [30:0] s_dly_r [SIN_PAD];

  always_ff @(posedge clk) begin
    if (en) begin
      r_dly_r[0] <= rd_r;
      q_dly_r[0] <= qd_r;
      s_dly_r[0] <= sin_c[SIN_STEPS].acc[30:0];
      for (int k = 1; k < LANE_LAT; k++) begin
        r_dly_r[k] <= r_dly_r[k-1];
        q_dly_r[k] <= q_dly_r[k-1];
      end
      for (int k = 1; k < SIN_PAD; k++) s_dly_r[k] <= s_dly_r[k-1];
    end
  end

  // output stages
  logic [61:0]        sp_r;
  logic signed [31:0] c_r;
  logic [1:0]         qe_r;
  logic signed [31:0] cos_raw, s_val, sn, cs;
  logic [31:0]        vm;
  logic [30:0]        snm, csm;
  logic [62:0]        pv_r;
  logic [60:0]        pwh_r;
  logic [62:0]        pwl_r;
  logic               sgn_v_r, sgn_w_r;
  logic [63:0]        twm;
  logic signed [65:0] vsn_r, tw_r, y;
  logic [32:0]        vsm;

  assign cos_raw = cos_c[COS_STEPS].acc;
  assign s_val   = (sp_r[61:30] > ONE_Q30) ? $signed(ONE_Q30) : $signed(sp_r[61:30]);

  always_comb begin
    case (qe_r)
      2'd0: begin sn = s_val;  cs = c_r;    end
      2'd1: begin sn = c_r;    cs = -s_val; end
      2'd2: begin sn = -s_val; cs = -c_r;   end
      default: begin sn = -c_r; cs = s_val; end
    endcase
  end

  assign vm  = fit.v[31] ? 32'(-33'(fit.v)) : 32'(fit.v);
  assign snm = sn[31] ? 31'(-sn) : 31'(sn);
  assign csm = cs[31] ? 31'(-cs) : 31'(cs);
  assign vsm = pv_r[62:30];
  assign twm = {pwh_r, 2'b00} + 64'(pwl_r[62:30]);
  assign y   = 66'(fit.o) + vsn_r + (fit.o[63] ? tw_r : -tw_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r  <= 62'(r_dly_r[LANE_LAT-1]) * 62'(s_dly_r[SIN_PAD-1]);
      qe_r  <= q_dly_r[LANE_LAT-1];
      if (cos_raw > $signed(ONE_Q30)) c_r <= $signed(ONE_Q30);
      else if (cos_raw < -$signed(ONE_Q30)) c_r <= -$signed(ONE_Q30);
      else c_r <= cos_raw;
      pv_r    <= 63'(vm) * 63'(snm);
      pwh_r   <= 61'(fit.w[61:32]) * 61'(csm);
      pwl_r   <= 63'(fit.w[31:0]) * 63'(csm);
      sgn_v_r <= fit.v[31] ^ sn[31];
      sgn_w_r <= cs[31];
      vsn_r   <= sgn_v_r ? -$signed(66'(vsm)) : $signed(66'(vsm));
      tw_r    <= sgn_w_r ? -$signed(66'(twm)) : $signed(66'(twm));
      out_status <= fit.status;
      if (fit.status != ST_OK) out_curve_value <= '0;
      else if (y > 66'sh7FFF_FFFF) out_curve_value <= 32'sh7FFF_FFFF;
      else if (y < -66'sh8000_0000) out_curve_value <= 32'sh8000_0000;
      else out_curve_value <= 32'(y);
    end
  end

  assign out_valid = vld_r[DEPTH-1];

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !fit.busy)
    else $error("item taken during fit run");
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> fit.busy && !in_ready)
    else $error("configuration write did not start fit run");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_curve_value == '0)
    else $error("error result carries nonzero value");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

endmodule

/* sim/tb_top.sv */
// Testbench for sinusoid_boundary_fit_eval_top: a directed table, then random phases.
// Expected curve values come from a local fixed-point fit and sine predictor.
// Depends on sbf_pkg and the top-level RTL.
`timescale 1ns / 100ps

module tb_top;
  import sbf_pkg::*;

  localparam int FRAC = 16;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam longint ONE30 = 64'sd1 << 30;
  localparam int DRAIN = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_time_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_curve_value;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_START;
  logic [31:0] cfg_data = '0;

  sinusoid_boundary_fit_eval_top #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for results");
    $display("== FAIL ==");
    $finish;
  end

  // local copy of the fit registers
  logic [31:0] fit_start = '0, fit_bound = '0, fit_slope = '0;

  typedef struct {
    logic signed [31:0] value;
    status_t st;
  } curve_res_t;

  curve_res_t pending_curve[$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_cfg = 0, n_special = 0;
  int gap_max = 14, stall_max = 14;

  function automatic longint scale_q30(longint x, longint s);
    longint unsigned m, as, p;
    m  = x < 0 ? longint'(-x) : x;
    as = s < 0 ? longint'(-s) : s;
    p = (((m >> 32) * as) << 2) + (((m & M32) * as) >> 30);
    return ((x < 0) != (s < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint horner(longint r2, bit is_cos);
    longint acc, den;
    int n;
    acc = ONE30;
    n = is_cos ? COS_STEPS : SIN_STEPS;
    for (int i = 0; i < n; i++) begin
      den = is_cos ? COS_DEN[i] : SIN_DEN[i];
      acc = ONE30 - (r2 * acc) / (den <<< 30);
    end
    return acc;
  endfunction

  function automatic longint clamp_unit(longint x);
    if (x > ONE30) return ONE30;
    if (x < -ONE30) return -ONE30;
    return x;
  endfunction

  function automatic curve_res_t predict_curve(logic [31:0] tm);
    curve_res_t res;
    longint s1, s2, v, d, o, sn, cs, s, c, r, r2, tw, y;
    longint unsigned hi, lo, ang, x, dm, vm, q, a, w;
    logic [1:0] quad;
    s1 = longint'(signed'(fit_start));
    s2 = longint'(signed'(fit_bound));
    v  = longint'(signed'(fit_slope));
    d = s1 - s2;
    res.value = '0;
    if (d == 0) begin
      res.st = ST_EQUAL;
      return res;
    end
    dm = d < 0 ? -d : d;
    vm = v < 0 ? -v : v;
    q = (vm * vm) / dm;
    a = (dm + q) >> 1;
    w = (dm > q ? dm - q : q - dm) >> 1;
    if (vm > a) begin
      res.st = ST_OVERSLOPE;
      return res;
    end
    o = d > 0 ? s2 + longint'(a) : s2 - longint'(a);
    // binary angle: time scaled by 2^64/(2*pi), one turn = 2^32
    hi = longint'(tm) * longint'(TURN_K_HI);
    lo = longint'(tm) * longint'(TURN_K_LO);
    ang = ((hi + (lo >> 32)) >> FRAC) & M32;
    quad = ang[31:30];
    x = ang & 64'h3FFF_FFFF;
    r = (x * longint'(HALF_PI_Q30)) >> 30;
    r2 = (longint'(r) * longint'(r)) >>> 30;
    s = clamp_unit((r * horner(r2, 1'b0)) / ONE30);
    c = clamp_unit(horner(r2, 1'b1));
    case (quad)
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    tw = scale_q30(longint'(w), cs);
    y = o + scale_q30(v, sn) + (o < 0 ? tw : -tw);
    if (y > 64'sh7FFF_FFFF) y = 64'sh7FFF_FFFF;
    if (y < -64'sh8000_0000) y = -64'sh8000_0000;
    res.value = y[31:0];
    res.st = ST_OK;
    return res;
  endfunction

  // block is idle: everything returned and the pipe drained
  task automatic wait_drained();
    wait (pending_curve.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic load_fit(logic [31:0] s1, logic [31:0] s2, logic [31:0] v);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= CFG_START; cfg_data <= s1;
    @(posedge clk);
    cfg_index <= CFG_BOUND; cfg_data <= s2;
    @(posedge clk);
    cfg_index <= CFG_SLOPE; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fit_start = s1; fit_bound = s2; fit_slope = v;
    n_cfg++;
  endtask

  task automatic send_time(logic [31:0] tm, bit known, curve_res_t known_res);
    int gap;
    bit took;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_time_now <= tm;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    pending_curve.push_back(known ? known_res : predict_curve(tm));
    n_items++;
  endtask

  // result side: random stall per item, compare just before the accepting edge
  initial begin
    int stall;
    bit took;
    curve_res_t exp_res;
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid && rst_n;
        if (took) begin
          n_results++;
          if (pending_curve.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item: value %h status %0d",
                                       out_curve_value, out_status);
          end else begin
            exp_res = pending_curve.pop_front();
            if (exp_res.value !== out_curve_value || exp_res.st !== out_status) begin
              errors++;
              if (errors <= 10)
                $display("mismatch: exp value %h status %0d, got value %h status %0d",
                         exp_res.value, exp_res.st, out_curve_value, out_status);
            end
            if (exp_res.st != ST_OK) n_special++;
          end
        end
        @(posedge clk);
      end while (!took);
    end
  end

  typedef struct {
    bit reload;
    logic [31:0] s1, s2, v;
    logic [31:0] tm;
    bit known;
    logic signed [31:0] value;
    status_t st;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(bit reload, logic [31:0] s1, logic [31:0] s2, logic [31:0] v,
                         logic [31:0] tm, bit known, status_t st);
    dir_row_t row;
    row = '{reload, s1, s2, v, tm, known, 32'sd0, st};
    dir_rows.push_back(row);
  endtask

  initial begin
    curve_res_t known_res;
    logic [31:0] s1, s2, v;
    int mode, count;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: start equals bound
    add_row(0, 0, 0, 0, 32'h0000_0000, 1, ST_EQUAL);
    add_row(0, 0, 0, 0, 32'hFFFF_FFFF, 1, ST_EQUAL);
    add_row(1, 32'h1234_0000, 32'h1234_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1, ST_EQUAL);
    add_row(0, 0, 0, 0, 32'h8000_0000, 1, ST_EQUAL);
    // unit swing, zero slope, around quadrant edges
    add_row(1, 32'h0001_0000, 32'h0000_0000, 32'h0, 32'h0000_0000, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h0001_921F, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h0003_243F, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h0004_B65F, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h8000_0000, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'hFFFF_FFFF, 0, ST_OK);
    // widest span, positive and negative slopes; saturation
    add_row(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h0003_0000, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h5555_5555, 0, ST_OK);
    add_row(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h00C9_0FDB, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'hAAAA_AAAA, 0, ST_OK);
    // negative offset takes the positive phase
    add_row(1, 32'hFFFF_0000, 32'hFFFD_0000, 32'h0000_8000, 32'h0000_0000, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h0000_8000, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h0002_0000, 0, ST_OK);
    // slope much larger than span
    add_row(1, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h0001_0000, 0, ST_OK);
    add_row(0, 0, 0, 0, 32'h7FFF_FFFF, 0, ST_OK);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].reload) begin
        in_valid <= 1'b0;
        load_fit(dir_rows[i].s1, dir_rows[i].s2, dir_rows[i].v);
      end
      known_res.value = dir_rows[i].value;
      known_res.st = dir_rows[i].st;
      send_time(dir_rows[i].tm, dir_rows[i].known, known_res);
    end

    for (int ph = 0; ph < 12; ph++) begin
      mode = $urandom_range(0, 5);
      case (mode)
        0: begin s1 = $urandom; s2 = $urandom; v = $urandom; end
        1: begin s1 = $urandom; s2 = s1; v = $urandom; end
        2: begin
          s1 = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          s2 = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          v  = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        end
        3: begin s1 = $urandom; s2 = $urandom; v = 32'h0; end
        4: begin s1 = 32'h7FFF_FFFF; s2 = $urandom; v = 32'h8000_0000; end
        default: begin
          s1 = $urandom_range(0, 32'h0010_0000);
          s2 = s1 + $urandom_range(1, 32'h0001_0000);
          v  = $urandom_range(0, 32'h0000_FFFF);
        end
      endcase
      gap_max   = (ph % 4 == 1) ? 0 : 14;
      stall_max = (ph % 4 == 2) ? 0 : 14;
      in_valid <= 1'b0;
      load_fit(s1, s2, v);
      count = 90;
      for (int k = 0; k < count; k++) begin
        if (ph == 5 && k == 45) begin
          in_valid <= 1'b0;
          wait (pending_curve.size() == 0);
          @(posedge clk);
        end
        send_time(k % 3 == 0 ? $urandom_range(0, 32'h0010_0000) : $urandom, 0, known_res);
      end
    end
    in_valid <= 1'b0;
    gap_max = 14; stall_max = 14;

    wait_drained();
    $display("covered %0d items, %0d results (%0d flagged), %0d fit loads",
             n_items, n_results, n_special, n_cfg);
    $display("mismatches: %0d", errors);
    if (errors == 0 && pending_curve.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
